// ===== rtl/mep_pkg.sv =====
// Shared types and constants of the midpoint ellipse point generator.
package mep_pkg;

    localparam int COORD_BITS_DEF  = 11;
    localparam int RADIUS_BITS_DEF = 10;

    // Datapath operations issued by the sequencer.
    typedef enum logic [3:0] {
        OP_NOP       = 4'd0,
        OP_LOAD      = 4'd1,
        OP_SQ_A      = 4'd2,
        OP_SQ_B      = 4'd3,
        OP_GRAD_Y    = 4'd4,
        OP_INIT      = 4'd5,
        OP_EMIT_DONE = 4'd6,
        OP_EMIT_R1   = 4'd7,
        OP_EMIT_R2   = 4'd8,
        OP_DEC_R1    = 4'd9,
        OP_DEC_R2    = 4'd10,
        OP_SW_TX     = 4'd11,
        OP_SW_TY     = 4'd12,
        OP_SW_SBTX   = 4'd13,
        OP_SW_SATY   = 4'd14,
        OP_SW_FIN    = 4'd15
    } t_op;

    // Walk phase.
    typedef enum logic [1:0] {
        PH_DONE = 2'd0,
        PH_R1   = 2'd1,
        PH_R2   = 2'd2
    } t_phase;

    // Sequencer states, one-hot.
    typedef enum logic [10:0] {
        ST_IDLE    = 11'b000_0000_0001,
        ST_SQ_A    = 11'b000_0000_0010,
        ST_SQ_B    = 11'b000_0000_0100,
        ST_GRAD_Y  = 11'b000_0000_1000,
        ST_INIT    = 11'b000_0001_0000,
        ST_STEP    = 11'b000_0010_0000,
        ST_SW_TX   = 11'b000_0100_0000,
        ST_SW_TY   = 11'b000_1000_0000,
        ST_SW_SBTX = 11'b001_0000_0000,
        ST_SW_SATY = 11'b010_0000_0000,
        ST_SW_FIN  = 11'b100_0000_0000
    } t_state;

    typedef struct packed {
        t_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;   // output register empty or being taken this cycle
        logic dec_ge0;    // decision value is not negative
        logic y_zero;     // vertical offset is zero
        logic gx_gt_gy;   // x-gradient exceeds y-gradient
    } t_dp_status;

endpackage

// ===== rtl/midpoint_ellipse_point_generator_top.sv =====
// Step request: result registered in the cycle after acceptance; while the walk runs, the decision update
// follows each step before the next request is taken. Start request: no result; the next request is taken
// only after the setup states square-a, square-b, y-gradient and init. A step that moves the walk into region 2
// passes through the switch states, where the one shared multiplier recomputes the decision value over five operations.
// Reset is synchronous and active low; afterwards the walk is finished, and a step
// request returns a result with every field zero until a start request arrives.
module midpoint_ellipse_point_generator_top #(
    parameter int COORD_BITS  = mep_pkg::COORD_BITS_DEF,
    parameter int RADIUS_BITS = mep_pkg::RADIUS_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    // Request side.
    input  logic i_s_tvalid,
    output logic o_s_tready,
    // Fields from bit 0: center_x, center_y, radius_a, radius_b, zero padding.
    input  logic [((2 * COORD_BITS + 2 * RADIUS_BITS + 7) / 8) * 8 - 1:0] i_s_tdata,
    // cmd: 0 starts a new ellipse, 1 asks for the next point set.
    input  logic i_s_tuser,
    // Result side.
    output logic o_m_tvalid,
    input  logic i_m_tready,
    // Fields from bit 0: px_direct, py_direct, px_mirror_h, py_mirror_h,
    // px_mirror_v, py_mirror_v, px_mirror_both, py_mirror_both.
    output logic [8 * (COORD_BITS + 2) - 1:0] o_m_tdata,
    // point_valid.
    output logic o_m_tuser,
    // last: final point set of the ellipse.
    output logic o_m_tlast
);

    localparam int OB = COORD_BITS + 2;

    // The controller owns the walk phase and sequences the datapath. The datapath
    // holds the walk registers, one multiplier with a registered product, and the
    // output register; a new request is taken only once that register is empty or
    // its result is being taken in the same cycle.
    mep_pkg::t_dp_cmd    dp_cmd;
    mep_pkg::t_dp_status dp_status;

    logic signed [OB-1:0] px_direct, py_direct, px_mirror_h, py_mirror_h;
    logic signed [OB-1:0] px_mirror_v, py_mirror_v, px_mirror_both, py_mirror_both;

    mep_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_cmd_step (i_s_tuser),
        .i_status   (dp_status),
        .o_s_tready (o_s_tready),
        .o_cmd      (dp_cmd)
    );

    mep_datapath #(
        .COORD_BITS  (COORD_BITS),
        .RADIUS_BITS (RADIUS_BITS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (dp_cmd),
        .i_center_x       (i_s_tdata[COORD_BITS-1:0]),
        .i_center_y       (i_s_tdata[2*COORD_BITS-1:COORD_BITS]),
        .i_radius_a       (i_s_tdata[2*COORD_BITS+RADIUS_BITS-1:2*COORD_BITS]),
        .i_radius_b       (i_s_tdata[2*COORD_BITS+2*RADIUS_BITS-1:2*COORD_BITS+RADIUS_BITS]),
        .i_m_tready       (i_m_tready),
        .o_status         (dp_status),
        .o_out_valid      (o_m_tvalid),
        .o_point_valid    (o_m_tuser),
        .o_last           (o_m_tlast),
        .o_px_direct      (px_direct),
        .o_py_direct      (py_direct),
        .o_px_mirror_h    (px_mirror_h),
        .o_py_mirror_h    (py_mirror_h),
        .o_px_mirror_v    (px_mirror_v),
        .o_py_mirror_v    (py_mirror_v),
        .o_px_mirror_both (px_mirror_both),
        .o_py_mirror_both (py_mirror_both)
    );

    assign o_m_tdata = {py_mirror_both, px_mirror_both, py_mirror_v, px_mirror_v,
                        py_mirror_h, px_mirror_h, py_direct, px_direct};

`ifndef NO_ASSERTIONS
    // A waiting result that is not taken must hold off new requests.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |-> !o_s_tready)
        else $error("request accepted while the output register is blocked");

    // A start request is followed by its setup cycles.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && !i_s_tuser) |=> !o_s_tready)
        else $error("request accepted during ellipse setup");

    // Every step request puts a result in the output register on the next cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && i_s_tuser) |=> o_m_tvalid)
        else $error("step request produced no result");

    // The final point set is always a real one.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tlast) |-> o_m_tuser)
        else $error("last flag on a result without valid points");
`endif

endmodule

// ===== rtl/mep_datapath.sv =====
// Datapath of the ellipse generator: walk registers, shared multiplier, output register.
module mep_datapath #(
    parameter int COORD_BITS  = mep_pkg::COORD_BITS_DEF,
    parameter int RADIUS_BITS = mep_pkg::RADIUS_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  mep_pkg::t_dp_cmd               i_cmd,
    input  logic [COORD_BITS-1:0]          i_center_x,
    input  logic [COORD_BITS-1:0]          i_center_y,
    input  logic [RADIUS_BITS-1:0]         i_radius_a,
    input  logic [RADIUS_BITS-1:0]         i_radius_b,
    input  logic                           i_m_tready,
    output mep_pkg::t_dp_status            o_status,
    output logic                           o_out_valid,
    output logic                           o_point_valid,
    output logic                           o_last,
    output logic signed [COORD_BITS+1:0]   o_px_direct,
    output logic signed [COORD_BITS+1:0]   o_py_direct,
    output logic signed [COORD_BITS+1:0]   o_px_mirror_h,
    output logic signed [COORD_BITS+1:0]   o_py_mirror_h,
    output logic signed [COORD_BITS+1:0]   o_px_mirror_v,
    output logic signed [COORD_BITS+1:0]   o_py_mirror_v,
    output logic signed [COORD_BITS+1:0]   o_px_mirror_both,
    output logic signed [COORD_BITS+1:0]   o_py_mirror_both
);

    localparam int SQ_W = 2 * RADIUS_BITS;
    localparam int X_W  = RADIUS_BITS + 2;
    localparam int Y_W  = RADIUS_BITS + 2;
    localparam int G_W  = 3 * RADIUS_BITS + 4;
    localparam int D_W  = 4 * RADIUS_BITS + 8;
    localparam int M_W  = 2 * RADIUS_BITS + 6;
    localparam int P_W  = 2 * M_W;
    localparam int OB   = COORD_BITS + 2;
    localparam int EW   = ((COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS) + 4;

    logic [COORD_BITS-1:0]  r_cx, n_cx;
    logic [COORD_BITS-1:0]  r_cy, n_cy;
    logic [RADIUS_BITS-1:0] r_ra, n_ra;
    logic [X_W-1:0]         r_x, n_x;
    logic signed [Y_W-1:0]  r_y, n_y;
    logic signed [G_W-1:0]  r_gx, n_gx;
    logic signed [G_W-1:0]  r_gy, n_gy;
    logic signed [D_W-1:0]  r_dec, n_dec;
    logic [SQ_W-1:0]        r_sa, n_sa;
    logic [SQ_W-1:0]        r_sb, n_sb;
    logic signed [M_W-1:0]  r_tmp, n_tmp;
    logic signed [P_W-1:0]  r_prod;
    logic                   r_dflag, n_dflag;

    logic                   r_out_valid, n_out_valid;
    logic                   r_point_valid, n_point_valid;
    logic                   r_last, n_last;
    logic signed [OB-1:0]   r_xr, n_xr;
    logic signed [OB-1:0]   r_xl, n_xl;
    logic signed [OB-1:0]   r_yd, n_yd;
    logic signed [OB-1:0]   r_yu, n_yu;

    logic signed [M_W-1:0]  mul_a;
    logic signed [M_W-1:0]  mul_b;
    logic signed [P_W-1:0]  mul_p;

    logic signed [G_W-1:0]  sa_g, sb_g, prod_g, step_sum;
    logic signed [D_W-1:0]  sa_d, sb_d, prod_d;
    logic signed [M_W-1:0]  sa_m, sb_m, ra_m, y_m, tx_m, ty_m;
    logic signed [EW-1:0]   cx_e, cy_e, x_e, y_e;
    logic                   dec_ge0, dec_le0, y_zero;

    assign sa_g   = $signed(G_W'(r_sa));
    assign sb_g   = $signed(G_W'(r_sb));
    assign prod_g = G_W'(r_prod);
    assign sa_d   = $signed(D_W'(r_sa));
    assign sb_d   = $signed(D_W'(r_sb));
    assign prod_d = D_W'(r_prod);
    assign sa_m   = $signed(M_W'(r_sa));
    assign sb_m   = $signed(M_W'(r_sb));
    assign ra_m   = $signed(M_W'(r_ra));
    assign y_m    = M_W'(r_y);
    assign tx_m   = $signed(M_W'({r_x, 1'b1}));
    assign ty_m   = y_m - M_W'(1);

    assign cx_e = $signed(EW'(r_cx));
    assign cy_e = $signed(EW'(r_cy));
    assign x_e  = $signed(EW'(r_x));
    assign y_e  = EW'(r_y);

    assign dec_ge0 = !r_dec[D_W-1];
    assign dec_le0 = r_dec[D_W-1] || (r_dec == '0);
    assign y_zero  = (r_y == '0);

    // Multiplier operand selection; the product is always registered.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.op)
            mep_pkg::OP_SQ_A: begin
                mul_a = ra_m;
                mul_b = ra_m;
            end
            mep_pkg::OP_SQ_B: begin
                mul_a = y_m;
                mul_b = y_m;
            end
            mep_pkg::OP_GRAD_Y: begin
                mul_a = sa_m;
                mul_b = y_m;
            end
            mep_pkg::OP_SW_TX: begin
                mul_a = tx_m;
                mul_b = tx_m;
            end
            mep_pkg::OP_SW_TY: begin
                mul_a = ty_m;
                mul_b = ty_m;
            end
            mep_pkg::OP_SW_SBTX: begin
                mul_a = sb_m;
                mul_b = r_tmp;
            end
            mep_pkg::OP_SW_SATY: begin
                mul_a = sa_m;
                mul_b = r_tmp;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Gradient-side sum of the decision update.
    always_comb begin
        if (i_cmd.op == mep_pkg::OP_DEC_R1) begin
            step_sum = r_gx + sb_g - (r_dflag ? r_gy : '0);
        end else begin
            step_sum = (r_dflag ? r_gx : '0) - r_gy + sa_g;
        end
    end

    always_comb begin
        n_cx          = r_cx;
        n_cy          = r_cy;
        n_ra          = r_ra;
        n_x           = r_x;
        n_y           = r_y;
        n_gx          = r_gx;
        n_gy          = r_gy;
        n_dec         = r_dec;
        n_sa          = r_sa;
        n_sb          = r_sb;
        n_tmp         = r_tmp;
        n_dflag       = r_dflag;
        n_out_valid   = r_out_valid && !i_m_tready;
        n_point_valid = r_point_valid;
        n_last        = r_last;
        n_xr          = r_xr;
        n_xl          = r_xl;
        n_yd          = r_yd;
        n_yu          = r_yu;
        unique case (i_cmd.op)
            mep_pkg::OP_NOP: begin
            end
            mep_pkg::OP_LOAD: begin
                n_cx = i_center_x;
                n_cy = i_center_y;
                n_ra = i_radius_a;
                n_x  = '0;
                n_y  = $signed(Y_W'(i_radius_b));
                n_gx = '0;
            end
            mep_pkg::OP_SQ_A: begin
            end
            mep_pkg::OP_SQ_B: begin
                n_sa = SQ_W'(r_prod);
            end
            mep_pkg::OP_GRAD_Y: begin
                n_sb = SQ_W'(r_prod);
            end
            mep_pkg::OP_INIT: begin
                n_gy  = prod_g <<< 1;
                n_dec = (sb_d <<< 2) - (prod_d <<< 2) + sa_d;
            end
            mep_pkg::OP_EMIT_DONE: begin
                n_out_valid   = 1'b1;
                n_point_valid = 1'b0;
                n_last        = 1'b0;
                n_xr          = '0;
                n_xl          = '0;
                n_yd          = '0;
                n_yu          = '0;
            end
            mep_pkg::OP_EMIT_R1: begin
                n_out_valid   = 1'b1;
                n_point_valid = 1'b1;
                n_last        = y_zero && dec_ge0;
                n_xr          = OB'(cx_e + x_e);
                n_xl          = OB'(cx_e - x_e);
                n_yd          = OB'(cy_e + y_e);
                n_yu          = OB'(cy_e - y_e);
                n_dflag       = dec_ge0;
                n_x           = r_x + X_W'(1);
                n_gx          = r_gx + (sb_g <<< 1);
                if (dec_ge0) begin
                    n_y  = r_y - Y_W'(1);
                    n_gy = r_gy - (sa_g <<< 1);
                end
            end
            mep_pkg::OP_EMIT_R2: begin
                n_out_valid   = 1'b1;
                n_point_valid = 1'b1;
                n_last        = y_zero;
                n_xr          = OB'(cx_e + x_e);
                n_xl          = OB'(cx_e - x_e);
                n_yd          = OB'(cy_e + y_e);
                n_yu          = OB'(cy_e - y_e);
                n_dflag       = dec_le0;
                n_y           = r_y - Y_W'(1);
                n_gy          = r_gy - (sa_g <<< 1);
                if (dec_le0) begin
                    n_x  = r_x + X_W'(1);
                    n_gx = r_gx + (sb_g <<< 1);
                end
            end
            mep_pkg::OP_DEC_R1, mep_pkg::OP_DEC_R2: begin
                n_dec = r_dec + (D_W'(step_sum) <<< 2);
            end
            mep_pkg::OP_SW_TX: begin
            end
            mep_pkg::OP_SW_TY: begin
                n_tmp = M_W'(r_prod);
            end
            mep_pkg::OP_SW_SBTX: begin
                n_tmp = M_W'(r_prod) - sb_m;
            end
            mep_pkg::OP_SW_SATY: begin
                n_dec = prod_d;
            end
            mep_pkg::OP_SW_FIN: begin
                n_dec = r_dec + (prod_d <<< 2);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cx          <= n_cx;
        r_cy          <= n_cy;
        r_ra          <= n_ra;
        r_x           <= n_x;
        r_y           <= n_y;
        r_gx          <= n_gx;
        r_gy          <= n_gy;
        r_dec         <= n_dec;
        r_sa          <= n_sa;
        r_sb          <= n_sb;
        r_tmp         <= n_tmp;
        r_prod        <= mul_p;
        r_dflag       <= n_dflag;
        r_point_valid <= n_point_valid;
        r_last        <= n_last;
        r_xr          <= n_xr;
        r_xl          <= n_xl;
        r_yd          <= n_yd;
        r_yu          <= n_yu;
    end

    assign o_status.out_free = !r_out_valid || i_m_tready;
    assign o_status.dec_ge0  = dec_ge0;
    assign o_status.y_zero   = y_zero;
    assign o_status.gx_gt_gy = (r_gx > r_gy);

    assign o_out_valid      = r_out_valid;
    assign o_point_valid    = r_point_valid;
    assign o_last           = r_last;
    assign o_px_direct      = r_xr;
    assign o_py_direct      = r_yd;
    assign o_px_mirror_h    = r_xl;
    assign o_py_mirror_h    = r_yd;
    assign o_px_mirror_v    = r_xr;
    assign o_py_mirror_v    = r_yu;
    assign o_px_mirror_both = r_xl;
    assign o_py_mirror_both = r_yu;

endmodule

// ===== rtl/mep_ctrl.sv =====
// Sequencer of the ellipse generator: walk phase and datapath operation control.
module mep_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    input  logic                 i_cmd_step,
    input  mep_pkg::t_dp_status  i_status,
    output logic                 o_s_tready,
    output mep_pkg::t_dp_cmd     o_cmd
);

    mep_pkg::t_state r_state, n_state;
    mep_pkg::t_phase r_phase, n_phase;
    logic            r_fin, n_fin;
    logic            accept;

    assign o_s_tready = (r_state == mep_pkg::ST_IDLE) && i_status.out_free;
    assign accept     = i_s_tvalid && o_s_tready;

    always_comb begin
        n_state  = r_state;
        n_phase  = r_phase;
        n_fin    = r_fin;
        o_cmd.op = mep_pkg::OP_NOP;
        unique case (r_state)
            mep_pkg::ST_IDLE: begin
                if (accept && !i_cmd_step) begin
                    o_cmd.op = mep_pkg::OP_LOAD;
                    n_state  = mep_pkg::ST_SQ_A;
                end else if (accept) begin
                    case (r_phase)
                        mep_pkg::PH_R1: begin
                            o_cmd.op = mep_pkg::OP_EMIT_R1;
                            n_fin    = i_status.y_zero && i_status.dec_ge0;
                            n_state  = mep_pkg::ST_STEP;
                        end
                        mep_pkg::PH_R2: begin
                            o_cmd.op = mep_pkg::OP_EMIT_R2;
                            n_fin    = i_status.y_zero;
                            n_state  = mep_pkg::ST_STEP;
                        end
                        default: begin
                            o_cmd.op = mep_pkg::OP_EMIT_DONE;
                        end
                    endcase
                end
            end
            mep_pkg::ST_SQ_A: begin
                o_cmd.op = mep_pkg::OP_SQ_A;
                n_state  = mep_pkg::ST_SQ_B;
            end
            mep_pkg::ST_SQ_B: begin
                o_cmd.op = mep_pkg::OP_SQ_B;
                n_state  = mep_pkg::ST_GRAD_Y;
            end
            mep_pkg::ST_GRAD_Y: begin
                o_cmd.op = mep_pkg::OP_GRAD_Y;
                n_state  = mep_pkg::ST_INIT;
            end
            mep_pkg::ST_INIT: begin
                o_cmd.op = mep_pkg::OP_INIT;
                n_phase  = mep_pkg::PH_R1;
                n_state  = mep_pkg::ST_IDLE;
            end
            mep_pkg::ST_STEP: begin
                o_cmd.op = (r_phase == mep_pkg::PH_R1) ? mep_pkg::OP_DEC_R1
                                                        : mep_pkg::OP_DEC_R2;
                n_state  = mep_pkg::ST_IDLE;
                if (r_fin) begin
                    n_phase = mep_pkg::PH_DONE;
                end else if ((r_phase == mep_pkg::PH_R1) && i_status.gx_gt_gy) begin
                    n_state = mep_pkg::ST_SW_TX;
                end
            end
            mep_pkg::ST_SW_TX: begin
                o_cmd.op = mep_pkg::OP_SW_TX;
                n_state  = mep_pkg::ST_SW_TY;
            end
            mep_pkg::ST_SW_TY: begin
                o_cmd.op = mep_pkg::OP_SW_TY;
                n_state  = mep_pkg::ST_SW_SBTX;
            end
            mep_pkg::ST_SW_SBTX: begin
                o_cmd.op = mep_pkg::OP_SW_SBTX;
                n_state  = mep_pkg::ST_SW_SATY;
            end
            mep_pkg::ST_SW_SATY: begin
                o_cmd.op = mep_pkg::OP_SW_SATY;
                n_state  = mep_pkg::ST_SW_FIN;
            end
            mep_pkg::ST_SW_FIN: begin
                o_cmd.op = mep_pkg::OP_SW_FIN;
                n_phase  = mep_pkg::PH_R2;
                n_state  = mep_pkg::ST_IDLE;
            end
            default: begin
                n_state = mep_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mep_pkg::ST_IDLE;
            r_phase <= mep_pkg::PH_DONE;
            r_fin   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_fin   <= n_fin;
        end
    end

endmodule
